FILE: hw/rtl/channel_demux_batch_averager_core_defines.svh
// Assertion helpers shared by the RTL; they expect clk and rst_n in scope.
`ifndef CHANNEL_DEMUX_BATCH_AVERAGER_CORE_DEFINES_SVH
`define CHANNEL_DEMUX_BATCH_AVERAGER_CORE_DEFINES_SVH

// Same-cycle implication.
`define CDBA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CDBA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/cdba_pkg.sv
`timescale 1ns / 1ps

package cdba_pkg;

    localparam int CH_W       = 4;
    localparam int SAMPLE_W   = 12;
    localparam int LIDX_W     = 2;
    localparam int AVG_W      = 12;
    localparam int TSUM_W     = 44;
    localparam int TCNT_W     = 32;
    localparam int BSUM_W     = 22;
    localparam int BCNT_W     = 10;
    localparam int MAP_W      = 40;
    localparam int CFG_DATA_W = 40;
    localparam int CFG_IDX_W  = 1;
    localparam int DIGIT_W    = 4;
    // dividend is batch sum plus half the count, one bit wider than the sum
    localparam int DVD_W      = BSUM_W + 1;

    localparam int MAP_CHANNELS = 10;
    localparam logic [CH_W-1:0]   MAP_IGNORE  = 4'hF;
    localparam logic [MAP_W-1:0]  MAP_RESET   = 40'hFF32FF1FF0;
    localparam logic [BCNT_W-1:0] BATCH_RESET = 10'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MAP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_SIZE  = 1'b1;

    localparam int NUM_LOGICAL_DEF  = 4;
    localparam int NUM_PHYSICAL_DEF = 10;
    localparam int SAMPLE_BITS_DEF  = 12;

    typedef struct packed {
        logic [CH_W-1:0]     physical_channel;
        logic [SAMPLE_W-1:0] sample_value;
    } smp_item_t;

    typedef struct packed {
        logic                accepted;
        logic [LIDX_W-1:0]   logical_index;
        logic                batch_done;
        logic [AVG_W-1:0]    batch_average;
        logic [TSUM_W-1:0]   total_sum;
        logic [TCNT_W-1:0]   total_count;
    } res_item_t;

endpackage

FILE: hw/rtl/cdba_dacc.sv
`timescale 1ns / 1ps

// Digit-serial accumulator: adds addend to acc_init one digit per cycle,
// rotating the accumulator through a shift register as the addend shifts out.
module cdba_dacc #(
    parameter int W = 44,
    parameter int D = cdba_pkg::DIGIT_W
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] acc_init,
    input  logic [W-1:0] addend,
    output logic         busy,
    output logic [W-1:0] sum
);

    localparam int NDIG  = (W + D - 1) / D;
    localparam int PW    = NDIG * D;
    localparam int CNT_W = $clog2(NDIG + 1);

    logic [PW-1:0]    acc_reg;
    logic [PW-1:0]    add_reg;
    logic             carry_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [D:0]       digit_next;

    assign digit_next = {1'b0, acc_reg[D-1:0]} + {1'b0, add_reg[D-1:0]}
                        + {{D{1'b0}}, carry_reg};
    assign busy = (cnt_reg != '0);
    assign sum  = acc_reg[W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(NDIG);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg   <= PW'(acc_init);
            add_reg   <= PW'(addend);
            carry_reg <= 1'b0;
        end
        else if (busy)
        begin
            acc_reg   <= {digit_next[D-1:0], acc_reg[PW-1:D]};
            add_reg   <= add_reg >> D;
            carry_reg <= digit_next[D];
        end
    end

endmodule

FILE: hw/rtl/cdba_sdiv.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, MSB first.
module cdba_sdiv #(
    parameter int DVD_W = cdba_pkg::DVD_W,
    parameter int DVS_W = cdba_pkg::BCNT_W,
    parameter int QUO_W = cdba_pkg::AVG_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [QUO_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] shf_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W:0]   partial;
    logic [DVS_W+1:0] diff;
    logic             ge;

    assign partial  = {rem_reg, shf_reg[DVD_W-1]};
    assign diff     = {1'b0, partial} - {2'b00, dvs_reg};
    assign ge       = !diff[DVS_W+1];
    assign busy     = (cnt_reg != '0);
    assign quotient = shf_reg[QUO_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(DVD_W);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // dividend bits shift out at the top while quotient bits shift in below
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            shf_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy)
        begin
            rem_reg <= ge ? diff[DVS_W-1:0] : partial[DVS_W-1:0];
            shf_reg <= {shf_reg[DVD_W-2:0], ge};
        end
    end

endmodule

FILE: hw/rtl/channel_demux_batch_averager_core.sv
// Multichannel block-average decimator.
// smp channel: one item is a physical channel tag and a raw sample. The
// channel map (register 0) sends it to a logical channel or drops it;
// register 1 sets the batch size (0 acts as 1). Both go in by cfg_we on the
// cfg port; the user must write them only while idle, unchecked by the block.
// res channel: one item per accepted sample: mapped flag, logical channel,
// batch-done flag, latest batch average, running sum and running count.
// Sums and counts are updated by 4-bit digit-serial adders, the 44-bit
// running sum being the widest. A mapped sample passes the states ACC
// (adders), CMP and, when its batch completes, DIV (bit-serial divide),
// then OUT; a dropped sample goes straight to OUT. A new item is taken
// only back in IDLE, so one item is in work at a time.
// The result sits in an output register, so the next sample is taken while
// a result waits; a stalled receiver holds the block once the next result
// is ready. Reset clears all per-channel state and loads the default map
// (channels 0, 3, 6, 7 to logical 0..3) and a batch size of 32.
`timescale 1ns / 1ps
`include "channel_demux_batch_averager_core_defines.svh"

module channel_demux_batch_averager_core #(
    parameter int NUM_LOGICAL  = cdba_pkg::NUM_LOGICAL_DEF,
    parameter int NUM_PHYSICAL = cdba_pkg::NUM_PHYSICAL_DEF,
    parameter int SAMPLE_BITS  = cdba_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               smp_valid,
    output logic                               smp_stall,
    input  cdba_pkg::smp_item_t                smp_item,
    output logic                               res_valid,
    input  logic                               res_stall,
    output cdba_pkg::res_item_t                res_item,
    input  logic                               cfg_we,
    input  logic [cdba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cdba_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int LG_W = (NUM_LOGICAL > 1) ? $clog2(NUM_LOGICAL) : 1;
    localparam logic [cdba_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
        (SAMPLE_BITS >= cdba_pkg::SAMPLE_W) ? '1
                                            : cdba_pkg::SAMPLE_W'((1 << SAMPLE_BITS) - 1);

    typedef enum logic [2:0] {ST_IDLE, ST_ACC, ST_CMP, ST_DIV, ST_OUT} state_t;

    state_t                          state_reg;
    logic [cdba_pkg::MAP_W-1:0]      map_reg;
    logic [cdba_pkg::BCNT_W-1:0]     bsize_reg;
    logic [cdba_pkg::CH_W-1:0]       nib_reg;
    logic                            drop_reg;
    logic                            done_reg;
    logic                            res_valid_reg;
    cdba_pkg::res_item_t             res_item_reg;

    logic [cdba_pkg::TSUM_W-1:0]     rsum_arr [NUM_LOGICAL];
    logic [cdba_pkg::TCNT_W-1:0]     rcnt_arr [NUM_LOGICAL];
    logic [cdba_pkg::BSUM_W-1:0]     bsum_arr [NUM_LOGICAL];
    logic [cdba_pkg::BCNT_W-1:0]     bcnt_arr [NUM_LOGICAL];
    logic [cdba_pkg::AVG_W-1:0]      avg_arr  [NUM_LOGICAL];

    logic [cdba_pkg::CH_W-1:0]       nib_in;
    logic [LG_W-1:0]                 lg_in;
    logic [LG_W-1:0]                 lg_cur;
    logic                            mapped_in;
    logic                            accept;
    logic                            acc_start;
    logic [cdba_pkg::SAMPLE_W-1:0]   sample_in;

    logic [cdba_pkg::TSUM_W-1:0]     rsum_q;
    logic [cdba_pkg::TCNT_W-1:0]     rcnt_q;
    logic [cdba_pkg::BSUM_W-1:0]     bsum_q;
    logic [cdba_pkg::BCNT_W-1:0]     bcnt_q;
    logic                            rsum_busy;
    logic                            rcnt_busy;
    logic                            bsum_busy;
    logic                            bcnt_busy;
    logic                            acc_busy;

    logic [cdba_pkg::BCNT_W-1:0]     limit;
    logic                            batch_hit;
    logic                            div_start;
    logic                            div_busy;
    logic [cdba_pkg::DVD_W-1:0]      dvd_next;
    logic [cdba_pkg::AVG_W-1:0]      quo;
    logic [cdba_pkg::AVG_W-1:0]      avg_next;
    logic                            res_fire;
    cdba_pkg::res_item_t             res_next;

    // map lookup for the incoming tag
    always_comb
    begin
        nib_in = cdba_pkg::MAP_IGNORE;
        for (int i = 0; i < cdba_pkg::MAP_CHANNELS; i++)
        begin
            if (smp_item.physical_channel == cdba_pkg::CH_W'(i))
            begin
                nib_in = map_reg[4*i +: 4];
            end
        end
    end

    assign mapped_in = ({1'b0, smp_item.physical_channel} < 5'(NUM_PHYSICAL))
                    && ({1'b0, nib_in} < 5'(NUM_LOGICAL))
                    && (nib_in != cdba_pkg::MAP_IGNORE);
    assign lg_in     = nib_in[LG_W-1:0];
    assign lg_cur    = nib_reg[LG_W-1:0];
    assign sample_in = smp_item.sample_value & SAMPLE_MASK;

    assign smp_stall = (state_reg != ST_IDLE);
    assign accept    = smp_valid && !smp_stall;
    assign acc_start = accept && mapped_in;

    cdba_dacc #(.W(cdba_pkg::TSUM_W), .D(cdba_pkg::DIGIT_W)) u_rsum (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (acc_start),
        .acc_init (rsum_arr[lg_in]),
        .addend   (cdba_pkg::TSUM_W'(sample_in)),
        .busy     (rsum_busy),
        .sum      (rsum_q)
    );

    cdba_dacc #(.W(cdba_pkg::TCNT_W), .D(cdba_pkg::DIGIT_W)) u_rcnt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (acc_start),
        .acc_init (rcnt_arr[lg_in]),
        .addend   (cdba_pkg::TCNT_W'(1)),
        .busy     (rcnt_busy),
        .sum      (rcnt_q)
    );

    cdba_dacc #(.W(cdba_pkg::BSUM_W), .D(cdba_pkg::DIGIT_W)) u_bsum (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (acc_start),
        .acc_init (bsum_arr[lg_in]),
        .addend   (cdba_pkg::BSUM_W'(sample_in)),
        .busy     (bsum_busy),
        .sum      (bsum_q)
    );

    cdba_dacc #(.W(cdba_pkg::BCNT_W), .D(cdba_pkg::DIGIT_W)) u_bcnt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (acc_start),
        .acc_init (bcnt_arr[lg_in]),
        .addend   (cdba_pkg::BCNT_W'(1)),
        .busy     (bcnt_busy),
        .sum      (bcnt_q)
    );

    assign acc_busy  = rsum_busy || rcnt_busy || bsum_busy || bcnt_busy;

    assign limit     = (bsize_reg == '0) ? cdba_pkg::BCNT_W'(1) : bsize_reg;
    assign batch_hit = (bcnt_q >= limit) && (bcnt_q != '0);
    assign div_start = (state_reg == ST_CMP) && batch_hit;
    // round to nearest: (sum + count/2) / count
    assign dvd_next  = cdba_pkg::DVD_W'(bsum_q) + cdba_pkg::DVD_W'(bcnt_q >> 1);

    cdba_sdiv #(
        .DVD_W (cdba_pkg::DVD_W),
        .DVS_W (cdba_pkg::BCNT_W),
        .QUO_W (cdba_pkg::AVG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_next),
        .divisor  (bcnt_q),
        .busy     (div_busy),
        .quotient (quo)
    );

    assign avg_next = done_reg ? quo : avg_arr[lg_cur];
    assign res_fire = (state_reg == ST_OUT) && (!res_valid_reg || !res_stall);

    always_comb
    begin
        res_next = '0;
        if (!drop_reg)
        begin
            res_next.accepted      = 1'b1;
            res_next.logical_index = nib_reg[cdba_pkg::LIDX_W-1:0];
            res_next.batch_done    = done_reg;
            res_next.batch_average = avg_next;
            res_next.total_sum     = rsum_q;
            res_next.total_count   = rcnt_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            map_reg       <= cdba_pkg::MAP_RESET;
            bsize_reg     <= cdba_pkg::BATCH_RESET;
            nib_reg       <= '0;
            drop_reg      <= 1'b0;
            done_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            res_item_reg  <= '0;
            for (int i = 0; i < NUM_LOGICAL; i++)
            begin
                rsum_arr[i] <= '0;
                rcnt_arr[i] <= '0;
                bsum_arr[i] <= '0;
                bcnt_arr[i] <= '0;
                avg_arr[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    cdba_pkg::CFG_CHANNEL_MAP: map_reg   <= cfg_data[cdba_pkg::MAP_W-1:0];
                    cdba_pkg::CFG_BATCH_SIZE:  bsize_reg <= cfg_data[cdba_pkg::BCNT_W-1:0];
                    default: ;
                endcase
            end

            if (res_fire)
            begin
                res_valid_reg <= 1'b1;
                res_item_reg  <= res_next;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        nib_reg   <= nib_in;
                        drop_reg  <= !mapped_in;
                        done_reg  <= 1'b0;
                        state_reg <= mapped_in ? ST_ACC : ST_OUT;
                    end
                end
                ST_ACC:
                begin
                    if (!acc_busy)
                    begin
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP:
                begin
                    done_reg  <= batch_hit;
                    state_reg <= batch_hit ? ST_DIV : ST_OUT;
                end
                ST_DIV:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (res_fire)
                    begin
                        if (!drop_reg)
                        begin
                            rsum_arr[lg_cur] <= rsum_q;
                            rcnt_arr[lg_cur] <= rcnt_q;
                            bsum_arr[lg_cur] <= done_reg ? '0 : bsum_q;
                            bcnt_arr[lg_cur] <= done_reg ? '0 : bcnt_q;
                            avg_arr[lg_cur]  <= avg_next;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    `CDBA_ASSERT_NXT(a_accept_leaves_idle, accept, state_reg != ST_IDLE, "accepted item not in work")
    `CDBA_ASSERT_IMP(a_cmp_adders_idle, state_reg == ST_CMP, !acc_busy && !div_busy, "adders busy at compare")
    `CDBA_ASSERT_IMP(a_div_only_on_batch, state_reg == ST_DIV, done_reg, "divide without a full batch")
    `CDBA_ASSERT_IMP(a_drop_is_zero, res_valid && !res_item.accepted, res_item.total_count == '0 && !res_item.batch_done, "dropped item not cleared")

endmodule
